@@ rtl/tcpb_pkg.sv @@
`timescale 1ns / 1ps

package tcpb_pkg;

  localparam int MAX_PACKET_BYTES = 256;
  localparam int HDR_BYTES        = 40;
  localparam int HDR_WORDS        = HDR_BYTES / 8;
  localparam int PAY_CAP          = MAX_PACKET_BYTES - HDR_BYTES;
  localparam int LEN_W            = $clog2(PAY_CAP + 1);
  localparam int PAY_ROWS         = (PAY_CAP + 7) / 8;
  localparam int ROW_W            = (PAY_ROWS > 1) ? $clog2(PAY_ROWS) : 1;
  localparam int ADDR_W           = ROW_W + 1;
  localparam int MEM_ROWS         = 2 ** ADDR_W;
  localparam int K_W              = $clog2((MAX_PACKET_BYTES + 7) / 8);
  localparam int SUM_STEPS        = 15;
  localparam int IP_STEPS         = 8;
  localparam int STEP_W           = $clog2(SUM_STEPS);
  localparam int FIFO_DEPTH       = 2;
  localparam int FPTR_W           = $clog2(FIFO_DEPTH);
  localparam int FCNT_W           = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_OUTST        = 2;
  localparam int OUTST_W          = $clog2(MAX_OUTST + 1);
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [31:0] RST_SRC_ADDR = 32'd167772687;
  localparam logic [31:0] RST_DST_ADDR = 32'd3468493286;
  localparam logic [15:0] RST_SRC_PORT = 16'd12345;
  localparam logic [15:0] RST_DST_PORT = 16'd1337;
  localparam logic [15:0] RST_WINDOW   = 16'd5480;
  localparam logic [7:0]  RST_TTL      = 8'd255;
  localparam logic [15:0] RST_IDENT    = 16'h1234;

  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  TCP_DOFF       = 8'h50;
  localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_ADDR = 3'd0,
    REG_DST_ADDR = 3'd1,
    REG_SRC_PORT = 3'd2,
    REG_DST_PORT = 3'd3,
    REG_WINDOW   = 3'd4,
    REG_TTL      = 3'd5,
    REG_IDENT    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] window;
    logic [7:0]  ttl;
    logic [15:0] ident;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [15:0]      psum;
    logic             ovf;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [7:0]       flags;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        lane;
    logic [7:0]        data;
  } wr_t;

  // ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

@@ rtl/tcpb_if.sv @@
`timescale 1ns / 1ps

interface tcpb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  payload_byte;
  logic [31:0] sequence_number;
  logic [31:0] acknowledge_number;
  logic [7:0]  tcp_flags;

  modport source (
    output valid, command, payload_byte, sequence_number, acknowledge_number, tcp_flags,
    input  ready
  );
  modport sink (
    input  valid, command, payload_byte, sequence_number, acknowledge_number, tcp_flags,
    output ready
  );
endinterface

interface tcpb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packet_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  logic        payload_overflow;

  modport source (
    output valid, packet_word, valid_bytes, last_word, payload_overflow,
    input  ready
  );
  modport sink (
    input  valid, packet_word, valid_bytes, last_word, payload_overflow,
    output ready
  );
endinterface

@@ rtl/tcpb_front.sv @@
`timescale 1ns / 1ps

module tcpb_front (
  input  logic                clk,
  input  logic                rst_n,
  tcpb_in_if.sink             in_ch,
  output tcpb_pkg::wr_t       wr,
  output logic                push,
  output tcpb_pkg::desc_t     push_desc,
  input  logic                done
);

  logic [tcpb_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [15:0]                  sum_r, sum_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         bank_r, bank_nxt;
  logic [tcpb_pkg::OUTST_W-1:0] outst_r, outst_nxt;
  logic                         acc_app, acc_fin, has_room;
  logic [15:0]                  term;

  assign in_ch.ready = (outst_r < tcpb_pkg::OUTST_W'(tcpb_pkg::MAX_OUTST));
  assign acc_app     = in_ch.valid && in_ch.ready && !in_ch.command;
  assign acc_fin     = in_ch.valid && in_ch.ready && in_ch.command;
  assign has_room    = (len_r < tcpb_pkg::LEN_W'(tcpb_pkg::PAY_CAP));
  // even offset is the high half of its 16-bit word
  assign term = len_r[0] ? {8'h00, in_ch.payload_byte} : {in_ch.payload_byte, 8'h00};

  always_comb begin
    wr.en   = acc_app && has_room;
    wr.addr = {bank_r, len_r[3 +: tcpb_pkg::ROW_W]};
    wr.lane = len_r[2:0];
    wr.data = in_ch.payload_byte;

    push            = acc_fin;
    push_desc.bank  = bank_r;
    push_desc.len   = len_r;
    push_desc.psum  = sum_r;
    push_desc.ovf   = ovf_r;
    push_desc.seq   = in_ch.sequence_number;
    push_desc.ack   = in_ch.acknowledge_number;
    push_desc.flags = in_ch.tcp_flags;

    len_nxt  = len_r;
    sum_nxt  = sum_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (acc_app) begin
      if (has_room) begin
        len_nxt = len_r + tcpb_pkg::LEN_W'(1);
        sum_nxt = tcpb_pkg::oc_add(sum_r, term);
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (acc_fin) begin
      len_nxt  = '0;
      sum_nxt  = '0;
      ovf_nxt  = 1'b0;
      bank_nxt = !bank_r;
    end

    outst_nxt = outst_r + tcpb_pkg::OUTST_W'(acc_fin) - tcpb_pkg::OUTST_W'(done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      outst_r <= '0;
    end else begin
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
      outst_r <= outst_nxt;
    end
  end

`ifndef SYNTH
  a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= tcpb_pkg::OUTST_W'(tcpb_pkg::MAX_OUTST))
    else $error("too many packets in flight");
  a_done_has_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (outst_r != '0))
    else $error("packet done with none in flight");
`endif

endmodule

@@ rtl/tcpb_fifo.sv @@
`timescale 1ns / 1ps

module tcpb_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcpb_pkg::desc_t push_desc,
  input  logic            pop,
  output tcpb_pkg::desc_t pop_desc,
  output logic            empty,
  output logic            full
);

  tcpb_pkg::desc_t             ent_r [tcpb_pkg::FIFO_DEPTH];
  logic [tcpb_pkg::FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tcpb_pkg::FCNT_W-1:0] cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == tcpb_pkg::FCNT_W'(tcpb_pkg::FIFO_DEPTH));
  assign pop_desc = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + tcpb_pkg::FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tcpb_pkg::FPTR_W'(1);
      end
      cnt_r <= cnt_r + tcpb_pkg::FCNT_W'(push) - tcpb_pkg::FCNT_W'(pop);
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("descriptor queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("descriptor queue underrun");
`endif

endmodule

@@ rtl/tcpb_back.sv @@
`timescale 1ns / 1ps

module tcpb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tcpb_pkg::cfg_t  cfg,
  input  tcpb_pkg::wr_t   wr,
  input  tcpb_pkg::desc_t head,
  input  logic            empty,
  output logic            pop,
  output logic            done,
  tcpb_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_HDR,
    S_FETCH,
    S_PAY
  } state_t;

  // payload store: two banks, one row of eight bytes per packet word
  logic [7:0][7:0] mem_r [tcpb_pkg::MEM_ROWS];
  logic [63:0]     rd_q_r;

  state_t                       state_r, state_nxt;
  tcpb_pkg::desc_t              d_r, d_nxt;
  logic [15:0]                  ip_acc_r, ip_acc_nxt;
  logic [15:0]                  tcp_acc_r, tcp_acc_nxt;
  logic [tcpb_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [tcpb_pkg::K_W-1:0]     k_r, k_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  out_word_r, out_word_nxt;
  logic [3:0]                   out_vb_r, out_vb_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  logic [15:0]                  tot16, nw16, tcp_len, ip_term, tcp_term;
  logic [tcpb_pkg::K_W-1:0]     last_k;
  logic [3:0]                   vb_last, vb;
  logic                         is_last, slot_free;
  logic [tcpb_pkg::ROW_W-1:0]   row_k;
  logic [0:4][63:0]             hdr_w;
  logic [63:0]                  pay_word;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr][3'd7 - wr.lane] <= wr.data;
    end
    rd_q_r <= mem_r[{d_r.bank, row_k}];
  end

  assign tot16   = 16'(tcpb_pkg::HDR_BYTES) + 16'(d_r.len);
  assign tcp_len = tcpb_pkg::TCP_HDR_BYTES + 16'(d_r.len);
  assign nw16    = (tot16 + 16'd7) >> 3;
  assign last_k  = tcpb_pkg::K_W'(nw16 - 16'd1);
  assign vb_last = (tot16[2:0] == 3'd0) ? 4'd8 : {1'b0, tot16[2:0]};
  assign is_last = (k_r == last_k);
  assign vb      = is_last ? vb_last : 4'd8;
  assign row_k   = tcpb_pkg::ROW_W'(k_r - tcpb_pkg::K_W'(tcpb_pkg::HDR_WORDS));

  assign hdr_w = {
    tcpb_pkg::IP_VER_IHL_TOS, tot16, cfg.ident, 16'h0000,
    cfg.ttl, tcpb_pkg::PROTO_TCP, ~ip_acc_r, cfg.src_addr, cfg.dst_addr,
    cfg.src_port, cfg.dst_port, d_r.seq, d_r.ack,
    tcpb_pkg::TCP_DOFF, d_r.flags, cfg.window, ~tcp_acc_r, 16'h0000
  };

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pay_word[63 - 8*i -: 8] = (4'(i) < vb) ? rd_q_r[63 - 8*i -: 8] : 8'h00;
    end
  end

  always_comb begin
    unique case (step_r)
      4'd0:    ip_term = tcpb_pkg::IP_VER_IHL_TOS;
      4'd1:    ip_term = tot16;
      4'd2:    ip_term = cfg.ident;
      4'd3:    ip_term = {cfg.ttl, tcpb_pkg::PROTO_TCP};
      4'd4:    ip_term = cfg.src_addr[31:16];
      4'd5:    ip_term = cfg.src_addr[15:0];
      4'd6:    ip_term = cfg.dst_addr[31:16];
      4'd7:    ip_term = cfg.dst_addr[15:0];
      default: ip_term = 16'h0000;
    endcase
    unique case (step_r)
      4'd0:    tcp_term = cfg.src_addr[31:16];
      4'd1:    tcp_term = cfg.src_addr[15:0];
      4'd2:    tcp_term = cfg.dst_addr[31:16];
      4'd3:    tcp_term = cfg.dst_addr[15:0];
      4'd4:    tcp_term = {8'h00, tcpb_pkg::PROTO_TCP};
      4'd5:    tcp_term = tcp_len;
      4'd6:    tcp_term = cfg.src_port;
      4'd7:    tcp_term = cfg.dst_port;
      4'd8:    tcp_term = d_r.seq[31:16];
      4'd9:    tcp_term = d_r.seq[15:0];
      4'd10:   tcp_term = d_r.ack[31:16];
      4'd11:   tcp_term = d_r.ack[15:0];
      4'd12:   tcp_term = {tcpb_pkg::TCP_DOFF, d_r.flags};
      4'd13:   tcp_term = cfg.window;
      4'd14:   tcp_term = d_r.psum;
      default: tcp_term = 16'h0000;
    endcase
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    ip_acc_nxt    = ip_acc_r;
    tcp_acc_nxt   = tcp_acc_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_word_nxt  = out_word_r;
    out_vb_nxt    = out_vb_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    pop           = 1'b0;
    done          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop         = 1'b1;
          d_nxt       = head;
          ip_acc_nxt  = '0;
          tcp_acc_nxt = '0;
          step_nxt    = '0;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        if (step_r < tcpb_pkg::STEP_W'(tcpb_pkg::IP_STEPS)) begin
          ip_acc_nxt = tcpb_pkg::oc_add(ip_acc_r, ip_term);
        end
        tcp_acc_nxt = tcpb_pkg::oc_add(tcp_acc_r, tcp_term);
        step_nxt    = step_r + tcpb_pkg::STEP_W'(1);
        if (step_r == tcpb_pkg::STEP_W'(tcpb_pkg::SUM_STEPS - 1)) begin
          k_nxt     = '0;
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hdr_w[k_r[2:0]];
          out_vb_nxt    = vb;
          out_last_nxt  = is_last;
          out_ovf_nxt   = d_r.ovf;
          k_nxt         = k_r + tcpb_pkg::K_W'(1);
          if (is_last) begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end else if (k_r == tcpb_pkg::K_W'(tcpb_pkg::HDR_WORDS - 1)) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_PAY;
      end
      S_PAY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = pay_word;
          out_vb_nxt    = vb;
          out_last_nxt  = is_last;
          out_ovf_nxt   = d_r.ovf;
          k_nxt         = k_r + tcpb_pkg::K_W'(1);
          if (is_last) begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r        <= d_nxt;
    ip_acc_r   <= ip_acc_nxt;
    tcp_acc_r  <= tcp_acc_nxt;
    step_r     <= step_nxt;
    k_r        <= k_nxt;
    out_word_r <= out_word_nxt;
    out_vb_r   <= out_vb_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.packet_word      = out_word_r;
  assign out_ch.valid_bytes      = out_vb_r;
  assign out_ch.last_word        = out_last_r;
  assign out_ch.payload_overflow = out_ovf_r;

`ifndef SYNTH
  a_done_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_valid_r && out_last_r))
    else $error("packet done without a last beat");
`endif

endmodule

@@ rtl/tcp_ipv4_packet_builder_core.sv @@
`timescale 1ns / 1ps

// IPv4/TCP segment builder.
// in_ch: command 0 appends payload_byte (one beat per cycle while in_ch.ready is high), command 1
// finishes the segment with sequence_number, acknowledge_number, tcp_flags.
// out_ch: the packet as 64-bit big-endian beats, 20-byte IPv4 header, 20-byte
// TCP header, then payload; valid_bytes marks the short last beat, last_word
// the final one, payload_overflow is set on every beat if bytes were dropped.
// cfg_we/cfg_index/cfg_data write the address, port, window, TTL and ident
// registers; write only while no packet is in flight.
// After the finish beat the checksums take 15 accumulation steps before the
// first beat; header beats go out one per cycle while the receiver is ready,
// payload beats one at a time (store row read, then output register).
// The payload store holds two packets in two banks, so appends for the next
// packet run while the previous one drains; in_ch.ready drops only while two
// finished packets are pending.
// A stalled receiver holds the output register; the back end waits.
// Reset clears packet state and restores the register defaults.

module tcp_ipv4_packet_builder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  tcpb_in_if.sink                       in_ch,
  tcpb_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [tcpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcpb_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcpb_pkg::cfg_t  cfg_r;
  tcpb_pkg::wr_t   wr;
  tcpb_pkg::desc_t push_desc, head;
  logic            push, pop, empty, full, done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_addr <= tcpb_pkg::RST_SRC_ADDR;
      cfg_r.dst_addr <= tcpb_pkg::RST_DST_ADDR;
      cfg_r.src_port <= tcpb_pkg::RST_SRC_PORT;
      cfg_r.dst_port <= tcpb_pkg::RST_DST_PORT;
      cfg_r.window   <= tcpb_pkg::RST_WINDOW;
      cfg_r.ttl      <= tcpb_pkg::RST_TTL;
      cfg_r.ident    <= tcpb_pkg::RST_IDENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcpb_pkg::REG_SRC_ADDR: cfg_r.src_addr <= cfg_data[31:0];
        tcpb_pkg::REG_DST_ADDR: cfg_r.dst_addr <= cfg_data[31:0];
        tcpb_pkg::REG_SRC_PORT: cfg_r.src_port <= cfg_data[15:0];
        tcpb_pkg::REG_DST_PORT: cfg_r.dst_port <= cfg_data[15:0];
        tcpb_pkg::REG_WINDOW:   cfg_r.window   <= cfg_data[15:0];
        tcpb_pkg::REG_TTL:      cfg_r.ttl      <= cfg_data[7:0];
        tcpb_pkg::REG_IDENT:    cfg_r.ident    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tcpb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wr        (wr),
    .push      (push),
    .push_desc (push_desc),
    .done      (done)
  );

  tcpb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (head),
    .empty     (empty),
    .full      (full)
  );

  tcpb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .wr     (wr),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("finish taken with descriptor queue full");
`endif

endmodule
